@@ sv/bds_pkg.sv @@
// Shared types and constants for the 2x2 box downscaler.
`default_nettype none

package bds_pkg;

    localparam int PIX_W        = 8;   // grey pixel
    localparam int PAIR_W       = 9;   // sum of two pixels
    localparam int BLOCK_SUM_W  = 11;  // sum of four pixels plus rounding bias
    localparam int WIDTH_REG_W  = 11;  // image_width register
    localparam int HEIGHT_REG_W = 16;  // image_height register
    localparam int CFG_DATA_W   = 16;  // widest register
    localparam int CFG_IDX_W    = 1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    // half-up rounding of a four-pixel mean: (sum + 2) >> 2
    localparam logic [BLOCK_SUM_W-1:0] ROUND_BIAS = 11'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // block in flight between the line-store read and the output register
    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic              row_end;
        logic              frame_end;
    } t_blk;

endpackage

`default_nettype wire

@@ sv/bds_ifs.sv @@
// Valid/ready channel interfaces: pixel input, result output, register writes.
`default_nettype none

interface bds_pix_if;
    import bds_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bds_res_if;
    import bds_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output out_pixel, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                    output ready);
endinterface

interface bds_cfg_if;
    import bds_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bds_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module bds_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/box_downscale_2x2_unit.sv @@
// Top level of the 2x2 box-filter downscaler with its line store.
`default_nettype none

// 2x2 box downscaler for an 8-bit grey raster stream. Pixels of an
// image_width x image_height frame enter on i_pix, one per clock at full rate;
// each aligned 2x2 block gives one pixel (sum + 2) >> 2 on o_res, flagged
// row_end on the last block of an output row and frame_end on the last block
// of the frame. An odd last column or row is dropped; width or height of 1
// gives no output. Register 0 is image_width (0 acts as 1, values above
// MAX_WIDTH act as MAX_WIDTH), register 1 is image_height (0 acts as 1);
// write them between frames. Throughput is one pixel per clock unless o_res
// stalls; a result passes the block stage and output register after the
// pixel completing its block. The rate rests on the single line-store
// RAM, taking even-row pair sums, read once per block on odd rows. The RAM is
// not cleared after reset: every entry read on an odd row was written on the
// even row above it. o_res has its own register and the block stage ahead of
// it holds one more block, so input keeps flowing while one result waits;
// i_pix.ready drops only when a second block completes behind a stalled
// result, and it follows o_res.ready in the same cycle.
module box_downscale_2x2_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bds_cfg_if.sink    i_cfg,
    bds_pix_if.sink    i_pix,
    bds_res_if.source  o_res
);

    import bds_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    // column counter and effective width share one width
    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int RW         = HEIGHT_REG_W;
    localparam logic [CW-1:0] MAX_W_C  = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] W_RESET  =
        (int'(WIDTH_RESET) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(WIDTH_RESET);

    // ---------------- configuration ----------------
    logic [CW-1:0] r_eff_w;
    logic [RW-1:0] r_eff_h;
    logic [CW-1:0] n_eff_w;
    logic [RW-1:0] n_eff_h;
    logic          cfg_wr;
    logic [WIDTH_REG_W-1:0] cfg_w_raw;

    assign i_cfg.ready = i_rst_n;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign cfg_w_raw   = i_cfg.data[WIDTH_REG_W-1:0];

    // clamp on write so the datapath sees only legal sizes
    always_comb begin
        n_eff_w = r_eff_w;
        n_eff_h = r_eff_h;
        if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH: begin
                    if (cfg_w_raw == '0) begin
                        n_eff_w = CW'(1);
                    end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
                        n_eff_w = MAX_W_C;
                    end else begin
                        n_eff_w = CW'(cfg_w_raw);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    n_eff_h = (i_cfg.data[RW-1:0] == '0) ? RW'(1) : i_cfg.data[RW-1:0];
                end
                default: begin
                    n_eff_h = r_eff_h;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= W_RESET;
            r_eff_h <= HEIGHT_RESET;
        end else begin
            r_eff_w <= n_eff_w;
            r_eff_h <= n_eff_h;
        end
    end

    // ---------------- position and pair sum ----------------
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [PIX_W-1:0] r_left;
    logic             r_s1_valid;
    t_blk             r_s1;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_row_end;
    logic             r_out_frame_end;

    logic             s1_move;
    logic             accept;
    logic [PAIR_W-1:0] pair;
    logic [CW-2:0]    slot_full;
    logic [AW-1:0]    slot;
    logic             line_wr;
    logic             line_rd;
    logic [PAIR_W-1:0] line_q;
    logic             col_wrap;
    logic             row_wrap;
    logic             last_col;
    logic             last_row;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = i_rst_n && (!r_s1_valid || s1_move);
    assign accept      = i_pix.valid && i_pix.ready;

    assign pair = PAIR_W'(r_left) + PAIR_W'(i_pix.pixel);

    // slot = (col / 2) mod line depth; col/2 reaches the depth only for odd MAX_WIDTH
    assign slot_full = r_col[CW-1:1];
    assign slot      = (slot_full >= (CW-1)'(LINE_DEPTH)) ? '0 : slot_full[AW-1:0];

    // even rows store pair sums, odd rows fetch them
    assign line_wr = accept && r_col[0] && !r_row[0];
    assign line_rd = accept && r_col[0] &&  r_row[0];

    assign col_wrap = ({1'b0, r_col} + (CW+1)'(1)) >= {1'b0, r_eff_w};
    assign row_wrap = ({1'b0, r_row} + (RW+1)'(1)) >= {1'b0, r_eff_h};
    assign last_col = ({1'b0, r_col} + (CW+1)'(2)) >= {1'b0, r_eff_w};
    assign last_row = ({1'b0, r_row} + (RW+1)'(2)) >= {1'b0, r_eff_h};

    bds_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (slot),
        .i_wr_data (pair),
        .i_rd_en   (line_rd),
        .i_rd_addr (slot),
        .o_rd_data (line_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (accept) begin
            if (!r_col[0]) begin
                r_left <= i_pix.pixel;
            end
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // block stage: waits for the registered RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (line_rd) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_rd) begin
            r_s1.pair      <= pair;
            r_s1.row_end   <= last_col;
            r_s1.frame_end <= last_col && last_row;
        end
    end

    // ---------------- output register ----------------
    logic [BLOCK_SUM_W-1:0] block_sum;

    assign block_sum = BLOCK_SUM_W'(line_q) + BLOCK_SUM_W'(r_s1.pair) + ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pix       <= block_sum[PIX_W+1:2];
            r_out_row_end   <= r_s1.row_end;
            r_out_frame_end <= r_s1.frame_end;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_pixel = r_out_pix;
    assign o_res.row_end   = r_out_row_end;
    assign o_res.frame_end = r_out_frame_end;

endmodule

`default_nettype wire

@@ sv/bds_chk.sv @@
// Port-level checks for the 2x2 box downscaler and their bind.
`default_nettype none

module bds_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_pixel,
    input wire logic       i_row_end,
    input wire logic       i_frame_end
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_pixel) && $stable(i_row_end)
             && $stable(i_frame_end)))
        else $error("result changed while stalled");

    // the last block of a frame also closes its row
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_end) |-> i_row_end)
        else $error("frame_end without row_end");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a fresh result traces back to an accepted pixel through the block stage and output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("result without a completing pixel");

endmodule

bind box_downscale_2x2_unit bds_chk u_bds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pixel (o_res.out_pixel),
    .i_row_end   (o_res.row_end),
    .i_frame_end (o_res.frame_end)
);

`default_nettype wire

@@ verif/box_downscale_2x2_checker.sv @@
// Scoreboard for the 2x2 box downscaler: predicts block means and checks every result.
`timescale 1ns / 1ps

module box_downscale_2x2_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_pix_valid,
    input  wire logic                             i_pix_ready,
    input  wire logic [bds_pkg::PIX_W-1:0]        i_pix_pixel,
    input  wire logic                             i_res_valid,
    input  wire logic                             i_res_ready,
    input  wire logic [bds_pkg::PIX_W-1:0]        i_res_out_pixel,
    input  wire logic                             i_res_row_end,
    input  wire logic                             i_res_frame_end,
    output int                                    o_pending,
    output int                                    o_faults
);

    import bds_pkg::*;

    localparam int LINE_SLOTS   = MAX_WIDTH / 2;
    localparam int SHOWN_FAULTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             row_end;
        logic             frame_end;
    } t_block_mean;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [PIX_W-1:0]        left_hold;
    logic [PAIR_W-1:0]       pair_line [LINE_SLOTS];
    t_block_mean             pending_means [$];
    int                      fault_count = 0;

    initial begin
        o_pending = 0;
        o_faults  = 0;
    end

    function automatic int unsigned active_width();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    task automatic note_fault(input string field, input int want_val, input int got_val);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want_val, got_val);
        end
    endtask

    // One raster step: even columns park the left pixel, odd columns form a pair sum.
    // Even rows store pair sums, odd rows add the stored sum and yield one block mean.
    task automatic take_pixel(input logic [PIX_W-1:0] px);
        int unsigned       w;
        int unsigned       h;
        int unsigned       slot;
        int unsigned       sum;
        logic [PAIR_W-1:0] pair;
        t_block_mean       block;
        w = active_width();
        h = (height_reg == '0) ? 1 : height_reg;
        if (col_pos % 2 == 0) begin
            left_hold = px;
        end else begin
            pair = left_hold + px;
            slot = (col_pos / 2) % LINE_SLOTS;
            if (row_pos % 2 == 0) begin
                pair_line[slot] = pair;
            end else begin
                sum = pair_line[slot] + pair;
                block.mean      = PIX_W'((sum + 2) >> 2);  // half-up rounding
                block.row_end   = (col_pos + 2 >= w);
                block.frame_end = block.row_end && (row_pos + 2 >= h);
                pending_means.push_back(block);
            end
        end
        // positions past the last column or row wrap at the next advance
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_block_mean want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            left_hold  = '0;
            pending_means.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg_data[WIDTH_REG_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data[HEIGHT_REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                take_pixel(i_pix_pixel);
            end
            if (i_res_valid && i_res_ready) begin
                if (pending_means.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOWN_FAULTS) begin
                        $display("unexpected result: out_pixel %0d row_end %0d frame_end %0d",
                                 i_res_out_pixel, i_res_row_end, i_res_frame_end);
                    end
                end else begin
                    want = pending_means.pop_front();
                    if (i_res_out_pixel !== want.mean)
                        note_fault("out_pixel", want.mean, i_res_out_pixel);
                    if (i_res_row_end !== want.row_end)
                        note_fault("row_end", want.row_end, i_res_row_end);
                    if (i_res_frame_end !== want.frame_end)
                        note_fault("frame_end", want.frame_end, i_res_frame_end);
                end
            end
        end
        o_pending <= pending_means.size();
        o_faults  <= fault_count;
    end

endmodule

@@ verif/box_downscale_2x2_unit_tb.sv @@
// Testbench top for box_downscale_2x2_unit: raster stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module box_downscale_2x2_unit_tb;
    import bds_pkg::*;

    localparam int MAX_WIDTH      = 1024;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;     // a result passes the block stage and output register after its pixel
    localparam int WATCHDOG_LIMIT = 2000;  // far beyond the longest random stall
    localparam int PHASE_ITEMS    = 180;   // random pixels per pacing phase
    localparam int JUNK_W         = CFG_DATA_W - WIDTH_REG_W;

    logic clk = 1'b0;
    logic rst_n;
    logic res_accept = 1'b0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   idle_cycles        = 0;
    int   pending;
    int   faults;

    bds_cfg_if cfg_ch ();
    bds_pix_if pix_ch ();
    bds_res_if res_ch ();

    assign res_ch.ready = res_accept;

    box_downscale_2x2_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    box_downscale_2x2_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_ch.valid),
        .i_cfg_ready     (cfg_ch.ready),
        .i_cfg_index     (cfg_ch.index),
        .i_cfg_data      (cfg_ch.data),
        .i_pix_valid     (pix_ch.valid),
        .i_pix_ready     (pix_ch.ready),
        .i_pix_pixel     (pix_ch.pixel),
        .i_res_valid     (res_ch.valid),
        .i_res_ready     (res_ch.ready),
        .i_res_out_pixel (res_ch.out_pixel),
        .i_res_row_end   (res_ch.row_end),
        .i_res_frame_end (res_ch.frame_end),
        .o_pending       (pending),
        .o_faults        (faults)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result side: random back-pressure at the rate of the current phase.
    always @(posedge clk) begin
        res_accept <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: a run of cycles with no handshake on any channel means a hang.
    always @(posedge clk) begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register value as the block sees it: 0 acts as 1, large values clamp.
    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned cap);
        return (v == 0) ? 1 : ((v > cap) ? cap : v);
    endfunction

    // Register write request; valid drops once taken and is sampled low, so
    // back-to-back writes never lower and raise valid in the same step.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] height_val);
        write_reg(CFG_IMAGE_WIDTH, width_val);
        write_reg(CFG_IMAGE_HEIGHT, height_val);
    endtask

    // One pixel request, with random sender gaps ahead of it. Valid stays high
    // between back-to-back requests.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= value;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_pixel(PIX_W'($urandom_range(255)));
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline empty.
    // Registers are only written after this.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random frames, mostly tiny, some wider. A quarter of the taller frames switch
    // width at the start of an even row: that row rewrites every line slot the odd
    // row below will read, so no unwritten slot is ever fetched.
    task automatic run_frames(input int target);
        int                    sent;
        int unsigned           w;
        int unsigned           h;
        int unsigned           split;
        int unsigned           w2;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;
        sent = 0;
        while (sent < target) begin
            settle();
            if ($urandom_range(7) == 0) wdata = CFG_DATA_W'($urandom_range(80, 13));
            else                        wdata = CFG_DATA_W'($urandom_range(12));
            // upper data bits are not part of the width register
            if ($urandom_range(3) == 0)
                wdata[CFG_DATA_W-1:WIDTH_REG_W] = JUNK_W'($urandom_range(31));
            hdata = CFG_DATA_W'($urandom_range(9));
            if ($urandom_range(1) == 0) configure(wdata, hdata);
            else begin
                write_reg(CFG_IMAGE_HEIGHT, hdata);
                write_reg(CFG_IMAGE_WIDTH, wdata);
            end
            w = eff_dim(wdata[WIDTH_REG_W-1:0], MAX_WIDTH);
            h = eff_dim(hdata, 65535);
            if (h >= 3 && $urandom_range(3) == 0) begin
                split = 2 * $urandom_range((h - 1) / 2, 1);
                send_random(split * w);
                settle();
                wdata = CFG_DATA_W'($urandom_range(12));
                write_reg(CFG_IMAGE_WIDTH, wdata);
                w2 = eff_dim(wdata, MAX_WIDTH);
                send_random((h - split) * w2);
                sent += split * w + (h - split) * w2;
            end else begin
                send_random(w * h);
                sent += w * h;
            end
        end
        settle();
    endtask

    initial begin
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_IMAGE_WIDTH;
        cfg_ch.data  <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- phase 1: no idling on either side, directed cases first ----

        // zero width and height act as 1: each pixel is a whole frame, no output
        configure(16'd0, 16'd0);
        send_pixel(8'hFF); send_pixel(8'h00);
        settle();

        // full-scale block, then a block summing to 2 which rounds up to 1;
        // the second block carries both end marks
        configure(16'd4, 16'd2);
        send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h01);
        send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'h01); send_pixel(8'h00);
        settle();

        // odd last column and odd last row are dropped: one block out of 3x3
        configure(16'd3, 16'd3);
        send_pixel(8'd10); send_pixel(8'd20); send_pixel(8'd99);
        send_pixel(8'd30); send_pixel(8'd42); send_pixel(8'd99);
        send_pixel(8'd99); send_pixel(8'd99); send_pixel(8'd99);
        settle();

        // width shrinks mid-row: the column already past the new last one wraps at
        // the next pixel; the odd row then reads a block summing to 1 (rounds down)
        configure(16'd6, 16'd2);
        send_pixel(8'h01); send_pixel(8'h00); send_pixel(8'hC3); send_pixel(8'h3C);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        send_pixel(8'h5A);
        send_pixel(8'h00); send_pixel(8'h00);
        settle();

        run_frames(PHASE_ITEMS);

        // ---- phase 2: sender idles most of the time ----
        sender_idle_pct = 64;
        run_frames(PHASE_ITEMS);

        // ---- phase 3: receiver stalls most of the time ----
        sender_idle_pct    = 0;
        receiver_stall_pct = 64;
        run_frames(PHASE_ITEMS);

        // ---- phase 4: light idling on both sides ----
        sender_idle_pct    = 9;
        receiver_stall_pct = 9;

        // all-ones registers: width clamps to the maximum, height is the largest;
        // part of the first row, then a 2x3 size mid-row: the next pixel wraps into
        // an odd row that reads the slot the first row wrote, and the even row
        // after it closes the frame
        configure(16'hFFFF, 16'hFFFF);
        send_random(100);
        settle();
        configure(16'd2, 16'd3);
        send_random(5);
        run_frames(PHASE_ITEMS);

        settle();
        if (faults == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/bds_pkg.sv
sv/bds_ifs.sv
sv/bds_ram.sv
sv/box_downscale_2x2_unit.sv
sv/bds_chk.sv
verif/box_downscale_2x2_checker.sv
verif/box_downscale_2x2_unit_tb.sv
